### design/rc4_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RC4 stream cipher engine.
// No dependencies; imported by every module of the block.
package rc4_pkg;

  localparam int unsigned MAX_KEY_BYTES_DEF = 256;
  localparam int unsigned PERM_DEPTH        = 256;
  localparam int unsigned LEN_W             = 9;
  localparam logic [LEN_W-1:0] KEY_LEN_RESET = 9'd16;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SCHED = 2'd1;
  localparam logic [1:0] CMD_CRYPT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD,
    ST_KS_MIX,
    ST_KS_WN,
    ST_KS_WM,
    ST_CR_RI,
    ST_CR_RJ,
    ST_CR_WJ,
    ST_CR_WI,
    ST_CR_RK,
    ST_CR_OUT
  } state_t;

  typedef struct packed {
    logic       re;
    logic [7:0] raddr;
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
  } perm_req_t;

  typedef struct packed {
    logic       load;
    logic [7:0] out_byte;
    logic [7:0] keystream_byte;
    logic       last_out;
    logic       unkeyed;
  } result_t;

endpackage

### design/rc4_perm_mem.sv
`timescale 1ns / 1ps
// Permutation memory: 256 bytes, one write and one registered read port.
// Depends on rc4_pkg for the request type.
module rc4_perm_mem (
  input  logic              clk,
  input  rc4_pkg::perm_req_t req,
  output logic [7:0]        rdata
);
  import rc4_pkg::*;

  logic [7:0] mem [PERM_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/rc4_key_mem.sv
`timescale 1ns / 1ps
// Key store memory with one write and one registered read port.
// Depends on rc4_pkg for the default key store depth.
module rc4_key_mem #(
  parameter int unsigned MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF,
  parameter int unsigned KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
  input  logic           clk,
  input  logic           we,
  input  logic [KAW-1:0] waddr,
  input  logic [7:0]     wdata,
  input  logic           re,
  input  logic [KAW-1:0] raddr,
  output logic [7:0]     rdata
);
  import rc4_pkg::*;

  logic [7:0] mem [MAX_KEY_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/rc4_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for key loading, key scheduling and keystream generation.
// Depends on rc4_pkg; drives rc4_perm_mem and rc4_key_mem.
module rc4_ctrl #(
  parameter int unsigned MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF,
  parameter int unsigned KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_command,
  input  logic [7:0]                in_key_index,
  input  logic [7:0]                in_key_byte,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_last_byte,
  input  logic [rc4_pkg::LEN_W-1:0] key_length,
  input  logic                      out_free,
  output rc4_pkg::result_t          res,
  output rc4_pkg::perm_req_t        perm_req,
  input  logic [7:0]                perm_rdata,
  output logic                      key_we,
  output logic [KAW-1:0]            key_waddr,
  output logic [7:0]                key_wdata,
  output logic                      key_re,
  output logic [KAW-1:0]            key_raddr,
  input  logic [7:0]                key_rdata
);
  import rc4_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_KEY_BYTES);

  state_t         state_r, state_nxt;
  logic [7:0]     i_r, i_nxt;
  logic [7:0]     j_r, j_nxt;
  logic [7:0]     n_r, n_nxt;
  logic [7:0]     mix_r, mix_nxt;
  logic [7:0]     held_r, held_nxt;
  logic [KAW-1:0] kpos_r, kpos_nxt;
  logic           keyed_r, keyed_nxt;
  logic [7:0]     data_r, data_nxt;
  logic           last_r, last_nxt;
  logic [LEN_W-1:0] eff_len;
  logic [7:0]     mix_sum;
  logic           accept;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign mix_sum  = mix_r + key_rdata + perm_rdata;

  always_comb begin
    if (key_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (key_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = key_length;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_SCHED) begin
            state_nxt = ST_FILL;
          end else if (in_command == CMD_CRYPT) begin
            state_nxt = keyed_r ? ST_CR_RI : ST_CR_OUT;
          end
        end
      end
      ST_FILL: begin
        if (n_r == 8'hff) begin
          state_nxt = ST_KS_RD;
        end
      end
      ST_KS_RD:  state_nxt = ST_KS_MIX;
      ST_KS_MIX: state_nxt = ST_KS_WN;
      ST_KS_WN:  state_nxt = ST_KS_WM;
      ST_KS_WM:  state_nxt = (n_r == 8'hff) ? ST_IDLE : ST_KS_RD;
      ST_CR_RI:  state_nxt = ST_CR_RJ;
      ST_CR_RJ:  state_nxt = ST_CR_WJ;
      ST_CR_WJ:  state_nxt = ST_CR_WI;
      ST_CR_WI:  state_nxt = ST_CR_RK;
      ST_CR_RK:  state_nxt = ST_CR_OUT;
      ST_CR_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    i_nxt     = i_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    mix_nxt   = mix_r;
    held_nxt  = held_r;
    kpos_nxt  = kpos_r;
    keyed_nxt = keyed_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    perm_req  = '0;
    res       = '0;
    key_we    = 1'b0;
    key_waddr = in_key_index[KAW-1:0];
    key_wdata = in_key_byte;
    key_re    = 1'b0;
    key_raddr = kpos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          data_nxt = in_data_byte;
          last_nxt = in_last_byte;
          if (in_command == CMD_LOAD) begin
            key_we = ({1'b0, in_key_index} < MAX_LEN);
          end else if (in_command == CMD_SCHED) begin
            i_nxt = '0;
            j_nxt = '0;
            n_nxt = '0;
          end else if ((in_command == CMD_CRYPT) && keyed_r) begin
            i_nxt = i_r + 8'd1;
          end
        end
      end
      ST_FILL: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = n_r;
        perm_req.wdata = n_r;
        n_nxt          = n_r + 8'd1;
        kpos_nxt       = '0;
        mix_nxt        = '0;
      end
      ST_KS_RD: begin
        perm_req.re    = 1'b1;
        perm_req.raddr = n_r;
        key_re         = 1'b1;
      end
      ST_KS_MIX: begin
        held_nxt       = perm_rdata;
        mix_nxt        = mix_sum;
        perm_req.re    = 1'b1;
        perm_req.raddr = mix_sum;
      end
      ST_KS_WN: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = n_r;
        perm_req.wdata = perm_rdata;
      end
      ST_KS_WM: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = mix_r;
        perm_req.wdata = held_r;
        n_nxt          = n_r + 8'd1;
        if ((LEN_W'(kpos_r) + LEN_W'(1)) >= eff_len) begin
          kpos_nxt = '0;
        end else begin
          kpos_nxt = kpos_r + KAW'(1);
        end
        if (n_r == 8'hff) begin
          keyed_nxt = 1'b1;
        end
      end
      ST_CR_RI: begin
        perm_req.re    = 1'b1;
        perm_req.raddr = i_r;
      end
      ST_CR_RJ: begin
        held_nxt       = perm_rdata;
        j_nxt          = j_r + perm_rdata;
        perm_req.re    = 1'b1;
        perm_req.raddr = j_r + perm_rdata;
      end
      ST_CR_WJ: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = j_r;
        perm_req.wdata = held_r;
      end
      ST_CR_WI: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = i_r;
        perm_req.wdata = perm_rdata;
      end
      ST_CR_RK: begin
        perm_req.re    = 1'b1;
        perm_req.raddr = held_r + perm_rdata;
      end
      ST_CR_OUT: begin
        res.load           = out_free;
        res.keystream_byte = keyed_r ? perm_rdata : 8'h00;
        res.out_byte       = data_r ^ res.keystream_byte;
        res.last_out       = last_r;
        res.unkeyed        = !keyed_r;
      end
      default: begin
        perm_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      keyed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      keyed_r <= keyed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    mix_r  <= mix_nxt;
    held_r <= held_nxt;
    kpos_r <= kpos_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

endmodule

### design/rc4_stream_cipher.sv
`timescale 1ns / 1ps
// RC4 stream cipher engine, one command at a time. Load stores a key byte.
// Crypt after a key schedule swaps S[i] and S[j] and registers the keystream
// result; before any schedule it uses a zero keystream. Schedule: 256 fill
// writes, then 256 swap steps, all bound by the single permutation write port.
// Synchronous active-low reset clears indices, keyed flag and key length (16);
// the permutation and key memories are not cleared.
module rc4_stream_cipher #(
  parameter int unsigned MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [rc4_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_command,
  input  logic [7:0]                in_key_index,
  input  logic [7:0]                in_key_byte,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_last_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic [7:0]                out_keystream_byte,
  output logic                      out_last_out,
  output logic                      out_unkeyed
);
  import rc4_pkg::*;

  localparam int unsigned KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [LEN_W-1:0] key_len_r, key_len_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic [7:0]       out_ks_r;
  logic             out_last_r;
  logic             out_unkeyed_r;
  logic             out_free;
  result_t          res;
  perm_req_t        perm_req;
  logic [7:0]       perm_rdata;
  logic             key_we;
  logic [KAW-1:0]   key_waddr;
  logic [7:0]       key_wdata;
  logic             key_re;
  logic [KAW-1:0]   key_raddr;
  logic [7:0]       key_rdata;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    key_len_nxt = cfg_wr_en ? cfg_wr_data : key_len_r;
    if (res.load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r   <= KEY_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      key_len_r   <= key_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_byte_r    <= res.out_byte;
      out_ks_r      <= res.keystream_byte;
      out_last_r    <= res.last_out;
      out_unkeyed_r <= res.unkeyed;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_keystream_byte = out_ks_r;
  assign out_last_out       = out_last_r;
  assign out_unkeyed        = out_unkeyed_r;

  rc4_ctrl #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES),
    .KAW(KAW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_key_index (in_key_index),
    .in_key_byte  (in_key_byte),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .key_length   (key_len_r),
    .out_free     (out_free),
    .res          (res),
    .perm_req     (perm_req),
    .perm_rdata   (perm_rdata),
    .key_we       (key_we),
    .key_waddr    (key_waddr),
    .key_wdata    (key_wdata),
    .key_re       (key_re),
    .key_raddr    (key_raddr),
    .key_rdata    (key_rdata)
  );

  rc4_perm_mem u_perm_mem (
    .clk   (clk),
    .req   (perm_req),
    .rdata (perm_rdata)
  );

  rc4_key_mem #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES),
    .KAW(KAW)
  ) u_key_mem (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

endmodule
